// ===== src/assert_macros.svh =====
// Assertion helpers for the fan controller. Every check is clocked on clk and
// is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define DFC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define DFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFC_ASSERT_SAME(name, ante, cons, msg)
`define DFC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== src/dfc_pkg.sv =====
`default_nettype none

package dfc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DAMP_FACTOR  = 3'd0;
  localparam logic [2:0] CFG_TEMP_FLOOR   = 3'd1;
  localparam logic [2:0] CFG_SPEED_GAIN   = 3'd2;
  localparam logic [2:0] CFG_TRAIL_TICKS  = 3'd3;
  localparam logic [2:0] CFG_SPINUP_TICKS = 3'd4;
  localparam logic [2:0] CFG_MINIMUM_DUTY = 3'd5;

  // Register values after reset.
  localparam logic [7:0] RST_DAMP_FACTOR  = 8'd10;
  localparam logic [9:0] RST_TEMP_FLOOR   = 10'd300;
  localparam logic [9:0] RST_SPEED_GAIN   = 10'd100;
  localparam logic [7:0] RST_TRAIL_TICKS  = 8'd50;
  localparam logic [7:0] RST_SPINUP_TICKS = 8'd15;
  localparam logic [7:0] RST_MINIMUM_DUTY = 8'd178;

  // Duty and demand limits.
  localparam logic [7:0] FULL_DUTY  = 8'd255;
  localparam logic [7:0] DEMAND_CAP = 8'd200;
  localparam logic [6:0] FAN_CAP    = 7'd100;

  // Division by 100 as a multiply by 5243 and a right shift by 19; exact for
  // dividends up to 25500.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Restoring divider: one quotient bit per cycle over a 20-bit dividend.
  localparam int DIV_STEPS = 20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FDIV,
    ST_XCHK,
    ST_XMUL,
    ST_XDIV,
    ST_XSAT,
    ST_MAP0,
    ST_REC0,
    ST_MAP1,
    ST_REC1,
    ST_UPD
  } dfc_state_t;

endpackage

`default_nettype wire

// ===== src/dual_fan_temperature_control.sv =====
// Dual fan temperature controller. One input transfer is one control tick
// carrying a temperature sample and the two knob readings; it produces exactly
// one output transfer with both fan duties, the damped temperature and the
// combined demand. All multiplication and division runs through one shared
// multiplier and one restoring divider that yields a quotient bit per cycle,
// stepped by a small sequencer. Each tick divides by the averaging divisor,
// and by the range span only when there is cooling demand and a nonzero span.
// in_tready is low while a tick is worked on; a finished result sits in an
// output register, and the next tick is taken while it waits. Configuration
// is to be written through the cfg port only while idle; the block itself
// does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module dual_fan_temperature_control
  import dfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [9:0]  cfg_wdata,
  // Tick input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // temp_sample[9:0], threshold_pot[17:10],
                                       // range_pot[25:18], zero fill
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // fan_one_duty[7:0], fan_two_duty[15:8],
                                       // damped_temp[25:16], demand_percent[33:26],
                                       // zero fill
);

  // Configuration registers.
  logic [7:0] damp_factor_r;
  logic [9:0] temp_floor_r;
  logic [9:0] speed_gain_r;
  logic [7:0] trail_ticks_r;
  logic [7:0] spinup_ticks_r;
  logic [7:0] minimum_duty_r;

  // Sequencer and tick state.
  dfc_state_t state_r, state_nxt;
  logic [9:0]  sample_r, sample_nxt;
  logic [6:0]  offset_r, offset_nxt;
  logic [6:0]  span_r, span_nxt;
  logic [9:0]  ft_r, ft_nxt;
  logic        seeded_r, seeded_nxt;
  logic [7:0]  demand_r, demand_nxt;
  logic [14:0] prod_r, prod_nxt;
  logic [7:0]  scaled_r [2];
  logic [7:0]  scaled_nxt [2];

  // Divider registers.
  logic [19:0] dvd_r, dvd_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // Fan state.
  logic [7:0] duty_r [2];
  logic [7:0] duty_nxt [2];
  logic [7:0] spin_r [2];
  logic [7:0] spin_nxt [2];
  logic [7:0] trail_r [2];
  logic [7:0] trail_nxt [2];

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  // Shared multiplier and divider step.
  logic [14:0] mul_a;
  logic [12:0] mul_b;
  logic [27:0] mul_p;
  logic [8:0]  rem_sh;
  logic [8:0]  rem_sub;
  logic        q_bit;
  logic [19:0] dvd_step;
  logic [7:0]  rem_step;

  // Derived values.
  logic [7:0] div_s;
  logic [7:0] div_m1;
  logic [7:0] duty_span;
  logic [9:0] excess_s;
  logic [9:0] over_s;
  logic [6:0] pct [2];
  logic       in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A damping divisor of zero behaves as one.
  assign div_s     = (damp_factor_r == 8'd0) ? 8'd1 : damp_factor_r;
  assign div_m1    = div_s - 8'd1;
  assign duty_span = FULL_DUTY - minimum_duty_r;

  // Excess over the minimum temperature, floored at zero, and the part above
  // the knob offset.
  assign excess_s = (ft_r > temp_floor_r) ? (ft_r - temp_floor_r) : 10'd0;
  assign over_s   = excess_s - {3'd0, offset_r};

  // Split of the demand between the two fans.
  assign pct[0] = (demand_r > {1'b0, FAN_CAP}) ? FAN_CAP : demand_r[6:0];
  assign pct[1] = (demand_r > {1'b0, FAN_CAP}) ? 7'(demand_r - {1'b0, FAN_CAP}) : 7'd0;

  // Shared multiplier; operands chosen by the sequencer state.
  always_comb begin
    mul_a = 15'd0;
    mul_b = 13'd0;
    case (state_r)
      ST_FMUL: begin
        mul_a = {5'd0, ft_r};
        mul_b = {5'd0, div_m1};
      end
      ST_XMUL: begin
        mul_a = {5'd0, over_s};
        mul_b = {3'd0, speed_gain_r};
      end
      ST_MAP0: begin
        mul_a = {8'd0, pct[0]};
        mul_b = {5'd0, duty_span};
      end
      ST_MAP1: begin
        mul_a = {8'd0, pct[1]};
        mul_b = {5'd0, duty_span};
      end
      ST_REC0, ST_REC1: begin
        mul_a = prod_r;
        mul_b = RECIP_100;
      end
      default: begin
        mul_a = 15'd0;
        mul_b = 13'd0;
      end
    endcase
  end

  assign mul_p = {13'd0, mul_a} * {15'd0, mul_b};

  // One restoring division step: shift in the next dividend bit and subtract
  // the divisor when it fits.
  assign rem_sh   = {rem_r, dvd_r[19]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_step = q_bit ? rem_sub[7:0] : rem_sh[7:0];
  assign dvd_step = {dvd_r[18:0], q_bit};

  // Sequencer, datapath and fan update.
  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    offset_nxt    = offset_r;
    span_nxt      = span_r;
    ft_nxt        = ft_r;
    seeded_nxt    = seeded_r;
    demand_nxt    = demand_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    for (int k = 0; k < 2; k++) begin
      scaled_nxt[k] = scaled_r[k];
      duty_nxt[k]   = duty_r[k];
      spin_nxt[k]   = spin_r[k];
      trail_nxt[k]  = trail_r[k];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sample_nxt = in_tdata[9:0];
          offset_nxt = in_tdata[17:11];
          span_nxt   = in_tdata[25:19];
          // The first tick seeds the filter with its own sample.
          if (!seeded_r) begin
            ft_nxt     = in_tdata[9:0];
            seeded_nxt = 1'b1;
          end
          state_nxt = ST_FMUL;
        end
      end
      ST_FMUL: begin
        dvd_nxt   = mul_p[19:0] + {10'd0, sample_r};
        dvs_nxt   = div_s;
        rem_nxt   = 8'd0;
        cnt_nxt   = 5'd0;
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          ft_nxt    = dvd_step[9:0];
          state_nxt = ST_XCHK;
        end
      end
      ST_XCHK: begin
        demand_nxt = 8'd0;
        state_nxt  = ST_MAP0;
        if (excess_s > {3'd0, offset_r}) begin
          if (span_r == 7'd0) begin
            // No span: any excess saturates the demand unless gain is zero.
            demand_nxt = (speed_gain_r == 10'd0) ? 8'd0 : DEMAND_CAP;
          end else begin
            state_nxt = ST_XMUL;
          end
        end
      end
      ST_XMUL: begin
        dvd_nxt   = mul_p[19:0];
        dvs_nxt   = {1'b0, span_r};
        rem_nxt   = 8'd0;
        cnt_nxt   = 5'd0;
        state_nxt = ST_XDIV;
      end
      ST_XDIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_XSAT;
        end
      end
      ST_XSAT: begin
        demand_nxt = (dvd_r > {12'd0, DEMAND_CAP}) ? DEMAND_CAP : dvd_r[7:0];
        state_nxt  = ST_MAP0;
      end
      ST_MAP0: begin
        prod_nxt  = mul_p[14:0];
        state_nxt = ST_REC0;
      end
      ST_REC0: begin
        scaled_nxt[0] = mul_p[RECIP_SHIFT +: 8];
        state_nxt     = ST_MAP1;
      end
      ST_MAP1: begin
        prod_nxt  = mul_p[14:0];
        state_nxt = ST_REC1;
      end
      ST_REC1: begin
        scaled_nxt[1] = mul_p[RECIP_SHIFT +: 8];
        state_nxt     = ST_UPD;
      end
      ST_UPD: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid_r || out_tready) begin
          for (int k = 0; k < 2; k++) begin
            if (spin_r[k] != 8'd0) begin
              spin_nxt[k] = spin_r[k] - 8'd1;
            end else if (pct[k] == 7'd0) begin
              if (trail_r[k] != 8'd0) begin
                trail_nxt[k] = trail_r[k] - 8'd1;
              end else begin
                duty_nxt[k] = 8'd0;
              end
            end else begin
              trail_nxt[k] = trail_ticks_r;
              if (duty_r[k] == 8'd0) begin
                // Start from stop: full-duty burst.
                spin_nxt[k] = spinup_ticks_r;
                duty_nxt[k] = FULL_DUTY;
              end else begin
                duty_nxt[k] = minimum_duty_r + scaled_r[k];
              end
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, demand_r, ft_r, duty_nxt[1], duty_nxt[0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_factor_r  <= RST_DAMP_FACTOR;
      temp_floor_r   <= RST_TEMP_FLOOR;
      speed_gain_r   <= RST_SPEED_GAIN;
      trail_ticks_r  <= RST_TRAIL_TICKS;
      spinup_ticks_r <= RST_SPINUP_TICKS;
      minimum_duty_r <= RST_MINIMUM_DUTY;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DAMP_FACTOR:  damp_factor_r  <= cfg_wdata[7:0];
        CFG_TEMP_FLOOR:   temp_floor_r   <= cfg_wdata;
        CFG_SPEED_GAIN:   speed_gain_r   <= cfg_wdata;
        CFG_TRAIL_TICKS:  trail_ticks_r  <= cfg_wdata[7:0];
        CFG_SPINUP_TICKS: spinup_ticks_r <= cfg_wdata[7:0];
        CFG_MINIMUM_DUTY: minimum_duty_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Control state and tick state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ft_r        <= 10'd0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        duty_r[k]  <= 8'd0;
        spin_r[k]  <= 8'd0;
        trail_r[k] <= 8'd0;
      end
    end else begin
      state_r     <= state_nxt;
      ft_r        <= ft_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < 2; k++) begin
        duty_r[k]  <= duty_nxt[k];
        spin_r[k]  <= spin_nxt[k];
        trail_r[k] <= trail_nxt[k];
      end
    end
  end

  // Payload and divider registers.
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    offset_r   <= offset_nxt;
    span_r     <= span_nxt;
    demand_r   <= demand_nxt;
    prod_r     <= prod_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    for (int k = 0; k < 2; k++) begin
      scaled_r[k] <= scaled_nxt[k];
    end
  end

  // Checks.
  `DFC_ASSERT_NEXT(a_accept_starts_filter, in_xfer, (state_r == ST_FMUL) && seeded_r, "no filter start")
  `DFC_ASSERT_SAME(a_demand_capped, out_tvalid, out_tdata[33:26] <= DEMAND_CAP, "demand above cap")
  `DFC_ASSERT_SAME(a_spin_full_duty0, spin_r[0] != 8'd0, duty_r[0] == FULL_DUTY, "fan one spin-up")
  `DFC_ASSERT_SAME(a_spin_full_duty1, spin_r[1] != 8'd0, duty_r[1] == FULL_DUTY, "fan two spin-up")

endmodule

`default_nettype wire

// ===== dv/dual_fan_temperature_control_tb.sv =====
`timescale 1ns / 100ps

import dfc_pkg::*;

// One tick result as it sits in out_tdata[33:0].
typedef struct packed {
  logic [7:0] demand;
  logic [9:0] damped;
  logic [7:0] fan_two;
  logic [7:0] fan_one;
} tick_result_t;

// One complete register setting.
typedef struct {
  logic [7:0] damp;
  logic [9:0] temp_floor;
  logic [9:0] gain;
  logic [7:0] trail;
  logic [7:0] spinup;
  logic [7:0] min_duty;
} fan_setup_t;

// Mirror of the controller: it works out the result of every accepted tick
// and checks the results that come out against them in order.
class fan_control_model;
  logic [7:0]   damp;
  logic [9:0]   temp_floor;
  logic [9:0]   gain;
  logic [7:0]   trail_ticks;
  logic [7:0]   spinup_ticks;
  logic [7:0]   min_duty;
  int unsigned  avg;
  bit           seeded;
  logic [7:0]   duty[2];
  logic [7:0]   spin_left[2];
  logic [7:0]   trail_left[2];
  tick_result_t due_results[$];
  int           errors;
  int           checked;

  function new();
    damp         = RST_DAMP_FACTOR;
    temp_floor   = RST_TEMP_FLOOR;
    gain         = RST_SPEED_GAIN;
    trail_ticks  = RST_TRAIL_TICKS;
    spinup_ticks = RST_SPINUP_TICKS;
    min_duty     = RST_MINIMUM_DUTY;
    avg          = 0;
    seeded       = 1'b0;
    errors       = 0;
    checked      = 0;
    for (int k = 0; k < 2; k++) begin
      duty[k]       = '0;
      spin_left[k]  = '0;
      trail_left[k] = '0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [9:0] val);
    case (idx)
      CFG_DAMP_FACTOR:  damp         = val[7:0];
      CFG_TEMP_FLOOR:   temp_floor   = val;
      CFG_SPEED_GAIN:   gain         = val;
      CFG_TRAIL_TICKS:  trail_ticks  = val[7:0];
      CFG_SPINUP_TICKS: spinup_ticks = val[7:0];
      CFG_MINIMUM_DUTY: min_duty     = val[7:0];
      default: ;
    endcase
  endfunction

  // A fan in its spin-up burst only counts down; otherwise it follows its share.
  function void step_fan(int k, int unsigned pct);
    if (spin_left[k] != 0) begin
      spin_left[k]--;
      return;
    end
    if (pct > FAN_CAP) pct = 32'(FAN_CAP);
    if (pct == 0) begin
      if (trail_left[k] != 0) trail_left[k]--;
      else duty[k] = '0;
      return;
    end
    trail_left[k] = trail_ticks;
    if (duty[k] == 0) begin
      spin_left[k] = spinup_ticks;
      duty[k]      = FULL_DUTY;
    end else begin
      duty[k] = 8'(32'(min_duty) + pct * 32'(FULL_DUTY - min_duty) / 32'(FAN_CAP));
    end
  endfunction

  // Called for every accepted input transfer.
  function void take_tick(logic [9:0] reading, logic [7:0] thr_pot, logic [7:0] rng_pot);
    int unsigned offset, span, divisor, excess, demand;
    tick_result_t r;
    offset  = 32'(thr_pot >> 1);
    span    = 32'(rng_pot >> 1);
    divisor = (damp == 0) ? 32'd1 : 32'(damp);
    if (!seeded) begin
      avg    = 32'(reading);
      seeded = 1'b1;
    end
    avg = (((divisor - 1) * avg + 32'(reading)) / divisor) & 32'h3FF;

    excess = (avg > 32'(temp_floor)) ? avg - 32'(temp_floor) : 32'd0;
    if (excess <= offset) begin
      demand = 0;
    end else if (span == 0) begin
      demand = (gain == 0) ? 32'd0 : 32'(DEMAND_CAP);
    end else begin
      demand = (excess - offset) * 32'(gain) / span;
      if (demand > DEMAND_CAP) demand = 32'(DEMAND_CAP);
    end

    // Fan one takes up to 100 percent, the rest spills to fan two.
    step_fan(0, (demand > FAN_CAP) ? 32'(FAN_CAP) : demand);
    step_fan(1, (demand > FAN_CAP) ? demand - 32'(FAN_CAP) : 32'd0);

    r.fan_one = duty[0];
    r.fan_two = duty[1];
    r.damped  = avg[9:0];
    r.demand  = demand[7:0];
    due_results.push_back(r);
  endfunction

  // Called for every accepted output transfer.
  function void match_result(logic [39:0] data);
    tick_result_t got, want;
    got = data[33:0];
    checked++;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Result %0d arrived with no tick outstanding", checked);
      return;
    end
    want = due_results.pop_front();
    if (got.fan_one !== want.fan_one || got.fan_two !== want.fan_two ||
        got.damped !== want.damped || got.demand !== want.demand) begin
      errors++;
      if (errors <= 10)
        $display("Result %0d mismatch (expected/actual): fan_one %0d/%0d fan_two %0d/%0d %s",
                 checked, want.fan_one, got.fan_one, want.fan_two, got.fan_two,
                 $sformatf("damped %0d/%0d demand %0d/%0d",
                           want.damped, got.damped, want.demand, got.demand));
    end
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function int failures();
    if (due_results.size() != 0)
      $display("%0d expected results never arrived", due_results.size());
    return errors + due_results.size();
  endfunction
endclass

module dual_fan_temperature_control_tb;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [9:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  fan_control_model fan_mirror = new();

  // When set, neither side inserts idle cycles.
  bit burst_mode = 1'b0;

  dual_fan_temperature_control u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int clamp10(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // Extremes an eighth of the time each, otherwise a value in the usual span.
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned typ);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, typ);
    endcase
  endfunction

  function automatic fan_setup_t random_setup();
    fan_setup_t s;
    s.damp       = 8'(pick_value(0, 255, 20));
    s.temp_floor = 10'(pick_value(0, 1023, 1023));
    s.gain       = 10'(pick_value(0, 1023, 400));
    s.trail      = 8'(pick_value(0, 255, 16));
    s.spinup     = 8'(pick_value(0, 255, 12));
    s.min_duty   = 8'(pick_value(0, 255, 255));
    return s;
  endfunction

  // One register write; the caller drops the write enable afterward.
  task automatic put_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    fan_mirror.set_reg(idx, val);
  endtask

  task automatic apply_setup(input fan_setup_t s);
    put_reg(CFG_DAMP_FACTOR, 10'(s.damp));
    put_reg(CFG_TEMP_FLOOR, s.temp_floor);
    put_reg(CFG_SPEED_GAIN, s.gain);
    put_reg(CFG_TRAIL_TICKS, 10'(s.trail));
    put_reg(CFG_SPINUP_TICKS, 10'(s.spinup));
    put_reg(CFG_MINIMUM_DUTY, 10'(s.min_duty));
    cfg_we <= 1'b0;
  endtask

  // Offer one tick and hold it until the input transfer completes.
  task automatic send_tick(input logic [9:0] temp, input logic [7:0] thr_pot,
                           input logic [7:0] rng_pot);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, rng_pot, thr_pot, temp};
    do @(posedge clk); while (!in_tready);
    fan_mirror.take_tick(temp, thr_pot, rng_pot);
  endtask

  // Stop offering ticks and wait until every result has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (fan_mirror.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, then check each output transfer.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      fan_mirror.match_result(out_tdata);
    end
  end

  // Tick stimulus.
  initial begin : tick_source
    fan_setup_t s;
    int         base, step, jitter, temp_v;
    logic [7:0] thr_v, rng_v;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the first tick seeds the filter; a range knob below 2
    // saturates demand; hot ticks spill to fan two.
    send_tick(10'd1023, 8'd0, 8'd0);
    send_tick(10'd1023, 8'd0, 8'd255);
    send_tick(10'd0, 8'd255, 8'd255);
    send_tick(10'd0, 8'd0, 8'd1);
    send_tick(10'd512, 8'd128, 8'd3);
    send_tick(10'd700, 8'd20, 8'd2);
    send_tick(10'd301, 8'd1, 8'd1);
    send_tick(10'd299, 8'd0, 8'd0);
    send_tick(10'd850, 8'd60, 8'd40);
    send_tick(10'd640, 8'd0, 8'd200);

    // No damping, no trail, no spin-up, duty map starting from zero.
    settle();
    s = '{8'd1, 10'd0, 10'd1000, 8'd0, 8'd0, 8'd0};
    apply_setup(s);
    send_tick(10'd5, 8'd0, 8'd255);
    send_tick(10'd100, 8'd10, 8'd200);
    send_tick(10'd0, 8'd0, 8'd0);
    send_tick(10'd1023, 8'd255, 8'd255);
    send_tick(10'd50, 8'd100, 8'd100);
    send_tick(10'd260, 8'd4, 8'd255);

    // Damp factor zero and zero speed gain, all counters at their maximum.
    settle();
    s = '{8'd0, 10'd100, 10'd0, 8'd255, 8'd255, 8'd255};
    apply_setup(s);
    send_tick(10'd1023, 8'd0, 8'd0);
    send_tick(10'd900, 8'd10, 8'd50);
    send_tick(10'd0, 8'd0, 8'd0);

    // Heaviest damping with the highest threshold and gain.
    settle();
    s = '{8'd255, 10'd1023, 10'd1023, 8'd1, 8'd1, 8'd1};
    apply_setup(s);
    send_tick(10'd1023, 8'd0, 8'd0);
    send_tick(10'd512, 8'd77, 8'd9);

    // Random phases: the temperature walks around a base, in about half the phases
    // near the minimum temperature so that demand rises and falls through all ranges.
    for (int p = 0; p < 10; p++) begin
      settle();
      base = $urandom_range(0, 1023);
      s    = random_setup();
      if ($urandom_range(0, 1) == 1)
        s.temp_floor = 10'(clamp10(base - int'($urandom_range(0, 80))));
      apply_setup(s);
      for (int n = 0; n < 103; n++) begin
        if (n % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 15) == 0) begin
          base = $urandom_range(0, 1023);
        end else begin
          step = $urandom_range(0, 40);
          base = clamp10(base + step - 20);
        end
        jitter = $urandom_range(0, 16);
        temp_v = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                             : clamp10(base + jitter - 8);
        thr_v  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40));
        rng_v  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(0, 255));
        send_tick(temp_v[9:0], thr_v, rng_v);
      end
      burst_mode = 1'b0;
    end

    settle();
    repeat (60) @(posedge clk);
    if (fan_mirror.failures() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
